/* sv/dle_stx_etx_frame_receiver_top_defines.svh */
// ---------------------------------------------------------------------------
// dle_stx_etx_frame_receiver_top_defines
// assertion macros shared by the frame receiver modules
// ---------------------------------------------------------------------------
`ifndef DLE_STX_ETX_FRAME_RECEIVER_TOP_DEFINES_SVH
`define DLE_STX_ETX_FRAME_RECEIVER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked property, switched off while reset is high
`define DSER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also live during reset
`define DSER_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSER_ASSERT(lbl, prop, msg)
`define DSER_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* sv/dser_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dser_pkg
// constants, types and the crc helper of the dle/stx/etx frame receiver
// ---------------------------------------------------------------------------
package dser_pkg;

  // raw frame store
  localparam int RAW_BYTES = 16;
  localparam int RAW_AW    = $clog2(RAW_BYTES);
  localparam int RAW_CW    = $clog2(RAW_BYTES + 1);

  // field widths
  localparam int BYTE_W = 8;
  localparam int ADDR_W = 6;
  localparam int BIDX_W = 4;

  // line control characters
  localparam logic [BYTE_W-1:0] CH_DLE = 8'h10;
  localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
  localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;

  // crc-16, msb first
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // shortest frame: address plus two crc bytes
  localparam int MIN_LEN = 3;

  typedef enum logic [1:0] {
    ST_GOOD = 2'd0,
    ST_ADDR = 2'd1,
    ST_CRC  = 2'd2,
    ST_RUNT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_RX,
    S_START,
    S_SCAN_RD,
    S_SCAN_USE,
    S_CHECK,
    S_STATUS,
    S_EMIT_RD,
    S_EMIT_USE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    rx_enable;
    logic    scan_init;
    logic    emit_init;
    logic    rd_issue;
    logic    scan_use;
    logic    emit_use;
    logic    load_status;
    status_t status_code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_end;
    logic raw_runt;
    logic addr_bad;
    logic scan_done;
    logic ulen_runt;
    logic crc_bad;
    logic slot_free;
    logic kept;
    logic emit_last;
  } sts_t;

  // one byte through the crc register
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* sv/dser_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dser_if
// valid/ready channels of the frame receiver: line bytes, results, config
// ---------------------------------------------------------------------------

// received line bytes
interface dser_rx_if;
  logic                         valid;
  logic                         ready;
  logic [dser_pkg::BYTE_W-1:0]  rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// frame result items
interface dser_res_if;
  logic                         valid;
  logic                         ready;
  logic [dser_pkg::BYTE_W-1:0]  frame_byte;
  logic [dser_pkg::BIDX_W-1:0]  byte_index;
  logic                         last;
  logic [1:0]                   status;
  modport source (output valid, output frame_byte, output byte_index,
                  output last, output status, input ready);
  modport sink   (input valid, input frame_byte, input byte_index,
                  input last, input status, output ready);
endinterface

// station address writes
interface dser_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dser_pkg::ADDR_W-1:0]  station_address;
  modport source (output valid, output station_address, input ready);
  modport sink   (input valid, input station_address, output ready);
endinterface

/* sv/dser_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dser_ram
// simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module dser_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/dser_ctrl.sv */
`timescale 1ns / 1ps
`include "dle_stx_etx_frame_receiver_top_defines.svh"
// ---------------------------------------------------------------------------
// dser_ctrl
// frame receiver sequencer: receive, scan and check pass, emit pass
// ---------------------------------------------------------------------------
module dser_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  dser_pkg::sts_t   sts,
  output dser_pkg::cmd_t   cmd
);

  dser_pkg::state_t  state, state_next;
  dser_pkg::status_t code, code_next;

  // state and pending status code
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dser_pkg::S_RX;
      code  <= dser_pkg::ST_GOOD;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    code_next  = code;
    unique case (state)
      dser_pkg::S_RX: begin
        if (sts.frame_end) begin
          state_next = dser_pkg::S_START;
        end
      end
      dser_pkg::S_START: begin
        if (sts.raw_runt) begin
          code_next  = dser_pkg::ST_RUNT;
          state_next = dser_pkg::S_STATUS;
        end else begin
          state_next = dser_pkg::S_SCAN_RD;
        end
      end
      dser_pkg::S_SCAN_RD: begin
        state_next = dser_pkg::S_SCAN_USE;
      end
      dser_pkg::S_SCAN_USE: begin
        priority if (sts.addr_bad) begin
          code_next  = dser_pkg::ST_ADDR;
          state_next = dser_pkg::S_STATUS;
        end else if (sts.scan_done) begin
          state_next = dser_pkg::S_CHECK;
        end else begin
          state_next = dser_pkg::S_SCAN_RD;
        end
      end
      dser_pkg::S_CHECK: begin
        priority if (sts.ulen_runt) begin
          code_next  = dser_pkg::ST_RUNT;
          state_next = dser_pkg::S_STATUS;
        end else if (sts.crc_bad) begin
          code_next  = dser_pkg::ST_CRC;
          state_next = dser_pkg::S_STATUS;
        end else begin
          state_next = dser_pkg::S_EMIT_RD;
        end
      end
      dser_pkg::S_STATUS: begin
        if (sts.slot_free) begin
          state_next = dser_pkg::S_RX;
        end
      end
      dser_pkg::S_EMIT_RD: begin
        state_next = dser_pkg::S_EMIT_USE;
      end
      dser_pkg::S_EMIT_USE: begin
        if (sts.slot_free) begin
          if (sts.kept && sts.emit_last) begin
            state_next = dser_pkg::S_RX;
          end else begin
            state_next = dser_pkg::S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = dser_pkg::S_RX;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd             = '0;
    cmd.status_code = code;
    unique case (state)
      dser_pkg::S_RX: begin
        cmd.rx_enable = 1'b1;
      end
      dser_pkg::S_START: begin
        cmd.scan_init = !sts.raw_runt;
      end
      dser_pkg::S_SCAN_RD, dser_pkg::S_EMIT_RD: begin
        cmd.rd_issue = 1'b1;
      end
      dser_pkg::S_SCAN_USE: begin
        cmd.scan_use = 1'b1;
      end
      dser_pkg::S_CHECK: begin
        cmd.emit_init = !sts.ulen_runt && !sts.crc_bad;
      end
      dser_pkg::S_STATUS: begin
        cmd.load_status = sts.slot_free;
      end
      dser_pkg::S_EMIT_USE: begin
        cmd.emit_use = sts.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // checks
  `DSER_ASSERT_RST(a_reset_to_rx, rst |=> state == dser_pkg::S_RX, "not receiving after reset")
  `DSER_ASSERT(a_end_starts_check, sts.frame_end |=> state == dser_pkg::S_START, "frame end lost")
  `DSER_ASSERT(a_status_once, cmd.load_status |=> state == dser_pkg::S_RX, "status not single")

endmodule

/* sv/dser_dp.sv */
`timescale 1ns / 1ps
`include "dle_stx_etx_frame_receiver_top_defines.svh"
// ---------------------------------------------------------------------------
// dser_dp
// frame receiver datapath: framing, raw store, unstuff, crc, result register
// ---------------------------------------------------------------------------
module dser_dp (
  input  logic            clk,
  input  logic            rst,
  dser_rx_if.sink         rx,
  dser_cfg_if.sink        cfg,
  dser_res_if.source      res,
  input  dser_pkg::cmd_t  cmd,
  output dser_pkg::sts_t  sts
);

  localparam int AW = dser_pkg::RAW_AW;
  localparam int CW = dser_pkg::RAW_CW;
  localparam int BW = dser_pkg::BYTE_W;

  // configuration
  logic [dser_pkg::ADDR_W-1:0] station_address;

  // framing state
  logic          in_frame, in_frame_next;
  logic          escape_pending, escape_pending_next;
  logic [CW-1:0] raw_count, raw_count_next;
  logic [CW-1:0] rawlen, rawlen_next;
  logic          frame_end;
  logic          store_we;

  // pass state
  logic [CW-1:0] rd_idx;
  logic          pend;
  logic [CW-1:0] ulen;
  logic [CW-1:0] oidx;
  logic [15:0]   crc;
  logic [BW-1:0] sh1, sh2;

  // raw store read side
  logic [BW-1:0] rd_byte;
  logic          kept;
  logic          emit_last;

  // result register
  logic              out_valid;
  logic [BW-1:0]     out_byte;
  logic [dser_pkg::BIDX_W-1:0] out_index;
  logic              out_last;
  dser_pkg::status_t out_status;
  logic              slot_free;
  logic              out_load;

  logic rx_acc;
  logic overflow;
  logic eff_in;
  logic eff_esc;

  // station address register
  assign cfg.ready = !rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= '0;
    end else if (cfg.valid) begin
      station_address <= cfg.station_address;
    end
  end

  // line byte handling: hunt, store, restart, end of frame
  assign rx.ready = cmd.rx_enable && !rst;
  assign rx_acc   = rx.valid && cmd.rx_enable && !rst;
  assign overflow = in_frame && (raw_count >= CW'(dser_pkg::RAW_BYTES));
  assign eff_in   = in_frame && !overflow;
  assign eff_esc  = escape_pending && !overflow;

  always_comb begin
    in_frame_next       = in_frame;
    escape_pending_next = escape_pending;
    raw_count_next      = raw_count;
    rawlen_next         = rawlen;
    frame_end           = 1'b0;
    store_we            = 1'b0;
    if (rx_acc) begin
      if (!eff_in) begin
        in_frame_next  = 1'b0;
        raw_count_next = '0;
        priority if (rx.rx_byte == dser_pkg::CH_DLE) begin
          escape_pending_next = 1'b1;
        end else if (eff_esc && rx.rx_byte == dser_pkg::CH_STX) begin
          in_frame_next       = 1'b1;
          escape_pending_next = 1'b0;
        end else begin
          escape_pending_next = 1'b0;
        end
      end else begin
        store_we = 1'b1;
        priority if (eff_esc && rx.rx_byte == dser_pkg::CH_ETX) begin
          frame_end           = 1'b1;
          in_frame_next       = 1'b0;
          escape_pending_next = 1'b0;
          raw_count_next      = '0;
          // stored count less the closing dle and etx
          rawlen_next = (raw_count == '0) ? '0 : raw_count - CW'(1);
        end else if (eff_esc && rx.rx_byte == dser_pkg::CH_STX) begin
          escape_pending_next = 1'b0;
          raw_count_next      = '0;
        end else begin
          raw_count_next      = raw_count + CW'(1);
          escape_pending_next = (rx.rx_byte == dser_pkg::CH_DLE) ? !escape_pending : 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      raw_count      <= '0;
    end else begin
      in_frame       <= in_frame_next;
      escape_pending <= escape_pending_next;
      raw_count      <= raw_count_next;
    end
  end

  always_ff @(posedge clk) begin
    rawlen <= rawlen_next;
  end

  // raw frame store
  dser_ram #(
    .WIDTH (BW),
    .DEPTH (dser_pkg::RAW_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (raw_count[AW-1:0]),
    .wdata (rx.rx_byte),
    .re    (cmd.rd_issue),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_byte)
  );

  // second dle of a doubled pair is dropped
  assign kept      = !(pend && rd_byte == dser_pkg::CH_DLE);
  assign emit_last = (oidx + CW'(3)) == ulen;

  // scan and emit passes over the store
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      rd_idx <= '0;
      pend   <= 1'b0;
      ulen   <= '0;
      crc    <= dser_pkg::CRC_INIT;
    end else if (cmd.emit_init) begin
      rd_idx <= '0;
      pend   <= 1'b0;
      oidx   <= '0;
    end else if (cmd.rd_issue) begin
      rd_idx <= rd_idx + CW'(1);
    end else if (cmd.scan_use) begin
      pend <= kept && (rd_byte == dser_pkg::CH_DLE);
      if (kept) begin
        // crc trails by two bytes so the trailer stays out of it
        if (ulen >= CW'(2)) begin
          crc <= dser_pkg::crc_byte(crc, sh2);
        end
        sh2  <= sh1;
        sh1  <= rd_byte;
        ulen <= ulen + CW'(1);
      end
    end else if (cmd.emit_use) begin
      pend <= kept && (rd_byte == dser_pkg::CH_DLE);
      if (kept) begin
        oidx <= oidx + CW'(1);
      end
    end
  end

  // result register
  assign slot_free = !out_valid || res.ready;
  assign out_load  = cmd.load_status || (cmd.emit_use && kept);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      out_byte   <= '0;
      out_index  <= '0;
      out_last   <= 1'b1;
      out_status <= cmd.status_code;
    end else if (out_load) begin
      out_byte   <= rd_byte;
      out_index  <= oidx[dser_pkg::BIDX_W-1:0];
      out_last   <= emit_last;
      out_status <= dser_pkg::ST_GOOD;
    end
  end

  assign res.valid      = out_valid;
  assign res.frame_byte = out_byte;
  assign res.byte_index = out_index;
  assign res.last       = out_last;
  assign res.status     = out_status;

  // status to the controller
  always_comb begin
    sts           = '0;
    sts.frame_end = frame_end;
    sts.raw_runt  = rawlen < CW'(dser_pkg::MIN_LEN);
    sts.addr_bad  = (rd_idx == CW'(1)) &&
                    (rd_byte != {{(BW - dser_pkg::ADDR_W){1'b0}}, station_address});
    sts.scan_done = rd_idx == rawlen;
    sts.ulen_runt = ulen < CW'(dser_pkg::MIN_LEN);
    sts.crc_bad   = (sh2 != crc[7:0]) || (sh1 != crc[15:8]);
    sts.slot_free = slot_free;
    sts.kept      = kept;
    sts.emit_last = emit_last;
  end

  // checks
  `DSER_ASSERT(a_load_needs_slot, out_load |-> slot_free, "result overwritten")
  `DSER_ASSERT(a_count_bound, raw_count <= CW'(dser_pkg::RAW_BYTES), "raw count past store")
  `DSER_ASSERT(a_end_clears, frame_end |=> !in_frame && raw_count == '0, "frame end left state")
  `DSER_ASSERT(a_emit_in_frame, cmd.emit_use && kept |-> oidx < ulen, "emit beyond frame")

endmodule

/* sv/dle_stx_etx_frame_receiver_top.sv */
`timescale 1ns / 1ps
// Byte-stuffed frame receiver. Line bytes are taken one per clock while the
// block is receiving; each byte is handled in the cycle it is transferred.
// When DLE ETX closes a frame, the block stops taking bytes and makes two
// passes over the raw store through its single read port: a scan pass that
// checks the address, removes doubled DLEs and runs the CRC, then, for a
// good frame, an emit pass that sends the frame bytes. Input stays held off
// until the passes are done; a runt or a wrong address ends them earlier,
// and result-side stalls lengthen the hold-off.
// A runt, wrong address or CRC error gives one status result instead. The
// station address register may be written at any time the block is idle.
// ---------------------------------------------------------------------------
// dle_stx_etx_frame_receiver_top
// dle stx / dle etx deframer with address filter and crc-16 check
// ---------------------------------------------------------------------------
module dle_stx_etx_frame_receiver_top (
  input  logic        clk,
  input  logic        rst,
  dser_rx_if.sink     rx,
  dser_cfg_if.sink    cfg,
  dser_res_if.source  res
);

  dser_pkg::cmd_t cmd;
  dser_pkg::sts_t sts;

  // sequencer
  dser_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // datapath
  dser_dp u_dp (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .cfg (cfg),
    .res (res),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// checks the dle stx / dle etx frame receiver against an in-bench predictor:
// line bytes go in through bursts and gaps, result items are compared field
// by field as they arrive, and the station address is changed between phases
// ---------------------------------------------------------------------------
module testbench;
  import dser_pkg::*;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  typedef struct {
    logic [BYTE_W-1:0] frame_byte;
    logic [BIDX_W-1:0] byte_index;
    logic              last;
    status_t           status;
  } frame_result_t;

  typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PULSED} ready_mode_e;

  // frame predictor and store of the results it expects
  class frame_scoreboard;
    logic [ADDR_W-1:0] station_addr;
    bit                in_frame;
    bit                escape_seen;
    int                raw_count;
    logic [BYTE_W-1:0] raw_store[RAW_BYTES];
    frame_result_t     expected_q[$];
    int                errors;

    function new();
      station_addr = '0;
      in_frame     = 1'b0;
      escape_seen  = 1'b0;
      raw_count    = 0;
      errors       = 0;
    endfunction

    // crc-16 register, one bit at a time, msb first
    static function logic [15:0] crc16_step(logic [15:0] crc, logic [BYTE_W-1:0] b);
      logic fb;
      for (int k = BYTE_W - 1; k >= 0; k--) begin
        fb  = crc[15] ^ b[k];
        crc = {crc[14:0], 1'b0};
        if (fb) begin
          crc = crc ^ CRC_POLY;
        end
      end
      return crc;
    endfunction

    function void add_expected(logic [BYTE_W-1:0] fb, int idx, bit lst, status_t st);
      frame_result_t r;
      r.frame_byte = fb;
      r.byte_index = BIDX_W'(idx);
      r.last       = lst;
      r.status     = st;
      expected_q.push_back(r);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // one accepted line byte through the receiver state
    function void note_byte(logic [BYTE_W-1:0] b);
      byte_q_t     plain;
      logic [15:0] crc;
      int          rawlen;
      int          i;
      int          n;

      // a full store drops the frame, the byte is then seen while hunting
      if (in_frame && raw_count >= RAW_BYTES) begin
        in_frame    = 1'b0;
        escape_seen = 1'b0;
        raw_count   = 0;
      end

      // hunting for dle stx
      if (!in_frame) begin
        if (b == CH_DLE) begin
          escape_seen = 1'b1;
        end else if (escape_seen && b == CH_STX) begin
          in_frame    = 1'b1;
          escape_seen = 1'b0;
          raw_count   = 0;
        end else begin
          escape_seen = 1'b0;
        end
        return;
      end

      raw_store[raw_count] = b;
      raw_count++;

      // dle etx closes the frame
      if (escape_seen && b == CH_ETX) begin
        rawlen = (raw_count >= 2) ? raw_count - 2 : 0;
        if (rawlen < MIN_LEN) begin
          add_expected('0, 0, 1'b1, ST_RUNT);
        end else if (raw_store[0] != BYTE_W'(station_addr)) begin
          add_expected('0, 0, 1'b1, ST_ADDR);
        end else begin
          // collapse doubled dles, left to right
          i = 0;
          while (i < rawlen) begin
            if (raw_store[i] == CH_DLE && i + 1 < rawlen && raw_store[i + 1] == CH_DLE) begin
              i++;
            end
            plain.push_back(raw_store[i]);
            i++;
          end
          n = plain.size();
          if (n < MIN_LEN) begin
            add_expected('0, 0, 1'b1, ST_RUNT);
          end else begin
            crc = CRC_INIT;
            for (int j = 0; j < n - 2; j++) begin
              crc = crc16_step(crc, plain[j]);
            end
            if (plain[n - 2] != crc[7:0] || plain[n - 1] != crc[15:8]) begin
              add_expected('0, 0, 1'b1, ST_CRC);
            end else begin
              for (int j = 0; j < n - 2; j++) begin
                add_expected(plain[j], j, j == n - 3, ST_GOOD);
              end
            end
          end
        end
        in_frame    = 1'b0;
        escape_seen = 1'b0;
        raw_count   = 0;
        return;
      end

      // dle stx inside a frame starts it again
      if (escape_seen && b == CH_STX) begin
        raw_count   = 0;
        escape_seen = 1'b0;
        return;
      end
      escape_seen = (b == CH_DLE) ? !escape_seen : 1'b0;
    endfunction

    task report(string msg);
      if (errors < 50) begin
        $display("ERROR at %0t ns: %s", $time, msg);
      end
      errors++;
    endtask

    // one result transfer against the oldest expectation
    task check_result(frame_result_t got);
      frame_result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result byte=%02h idx=%0d last=%0d status=%0d",
                         got.frame_byte, got.byte_index, got.last, got.status));
      end else begin
        exp_r = expected_q.pop_front();
        if (got.frame_byte !== exp_r.frame_byte) begin
          report($sformatf("frame_byte %02h, expected %02h",
                           got.frame_byte, exp_r.frame_byte));
        end
        if (got.byte_index !== exp_r.byte_index) begin
          report($sformatf("byte_index %0d, expected %0d",
                           got.byte_index, exp_r.byte_index));
        end
        if (got.last !== exp_r.last) begin
          report($sformatf("last %0d, expected %0d", got.last, exp_r.last));
        end
        if (got.status !== exp_r.status) begin
          report($sformatf("status %0d, expected %0d", got.status, exp_r.status));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst;

  dser_rx_if  rx_ch ();
  dser_cfg_if cfg_ch ();
  dser_res_if res_ch ();

  dle_stx_etx_frame_receiver_top u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .cfg (cfg_ch),
    .res (res_ch)
  );

  frame_scoreboard sb = new();
  int              accepted_bytes = 0;
  int              burst_left     = 0;
  logic            hold_off       = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // line byte, biased towards the control characters
  function automatic logic [BYTE_W-1:0] rand_line_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      return CH_DLE;
    end else if (pick < 25) begin
      return CH_STX;
    end else if (pick < 30) begin
      return CH_ETX;
    end
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic byte_q_t rand_payload(int n);
    byte_q_t p;
    for (int k = 0; k < n; k++) begin
      p.push_back(rand_line_byte());
    end
    return p;
  endfunction

  // mostly short payloads, now and then up to the largest frame
  function automatic int rand_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(5, 11);
    end
    return $urandom_range(0, 4);
  endfunction

  // one line byte transfer; the sender works in bursts with gaps between
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    sb.note_byte(b);
    accepted_bytes++;
    burst_left--;
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) begin
      send_byte(q[i]);
    end
  endtask

  // address, payload and crc, dle-stuffed and framed
  task automatic send_frame(input logic [BYTE_W-1:0] addr, input byte_q_t payload,
                            input bit corrupt);
    byte_q_t     plain;
    byte_q_t     line;
    logic [15:0] crc;
    plain.push_back(addr);
    foreach (payload[i]) begin
      plain.push_back(payload[i]);
    end
    crc = CRC_INIT;
    foreach (plain[i]) begin
      crc = frame_scoreboard::crc16_step(crc, plain[i]);
    end
    if (corrupt) begin
      crc = crc ^ (16'd1 << $urandom_range(0, 15));
    end
    plain.push_back(crc[7:0]);
    plain.push_back(crc[15:8]);
    line.push_back(CH_DLE);
    line.push_back(CH_STX);
    foreach (plain[i]) begin
      line.push_back(plain[i]);
      if (plain[i] == CH_DLE) begin
        line.push_back(CH_DLE);
      end
    end
    line.push_back(CH_DLE);
    line.push_back(CH_ETX);
    send_bytes(line);
  endtask

  // sender pauses until every expected result is back and the block is quiet
  task automatic wait_results();
    rx_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_station(input logic [ADDR_W-1:0] v);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.station_address <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.station_addr = v;
  endtask

  // one randomly chosen piece of line traffic
  task automatic send_random_traffic();
    byte_q_t           q;
    logic [BYTE_W-1:0] station;
    logic [BYTE_W-1:0] other;
    int                pick;
    int                n;
    station = BYTE_W'(sb.station_addr);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_frame(station, rand_payload(rand_len()), 1'b0);
    end else if (pick < 65) begin
      send_frame(station, rand_payload(rand_len()), 1'b1);
    end else if (pick < 73) begin
      do other = BYTE_W'($urandom_range(0, 255)); while (other == station);
      send_frame(other, rand_payload(rand_len()), 1'b0);
    end else if (pick < 78) begin
      // runt, with the station address first now and then
      q = {CH_DLE, CH_STX};
      n = $urandom_range(0, 2);
      for (int k = 0; k < n; k++) begin
        q.push_back((k == 0 && $urandom_range(0, 1) == 1) ? station : rand_line_byte());
      end
      q.push_back(CH_DLE);
      q.push_back(CH_ETX);
      send_bytes(q);
    end else if (pick < 83) begin
      // too long for the raw store
      send_frame(station, rand_payload($urandom_range(12, 16)), 1'b0);
    end else if (pick < 90) begin
      // broken start, then a whole frame
      q = {CH_DLE, CH_STX};
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) begin
        q.push_back(rand_line_byte());
      end
      send_bytes(q);
      send_frame(station, rand_payload(rand_len()), 1'b0);
    end else begin
      send_bytes(rand_payload($urandom_range(1, 6)));
    end
  endtask

  // result side: check transfers, stall on a changing pattern
  initial begin : result_sink
    frame_result_t got;
    ready_mode_e   mode;
    int            mode_left;
    int            tick;
    logic          rdy;
    mode      = RDY_ALWAYS;
    mode_left = 0;
    tick      = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got.frame_byte = res_ch.frame_byte;
        got.byte_index = res_ch.byte_index;
        got.last       = res_ch.last;
        got.status     = status_t'(res_ch.status);
        sb.check_result(got);
      end
      if (mode_left == 0) begin
        mode      = ready_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      tick++;
      case (mode)
        RDY_ALWAYS: begin
          rdy = 1'b1;
        end
        RDY_RANDOM: begin
          rdy = 1'($urandom_range(0, 1));
        end
        default: begin
          rdy = (tick % 7) >= 3;
        end
      endcase
      res_ch.ready <= rdy && !hold_off;
    end
  end

  // one long hold-off on the result side while line bytes keep coming
  initial begin : long_stall
    while (accepted_bytes < 110) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // run limit
  initial begin : watchdog
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // reset, directed frames, then random phases under several addresses
  initial begin : stimulus
    byte_q_t           q;
    logic [ADDR_W-1:0] plan[5];
    int                target;
    rst                    <= 1'b1;
    rx_ch.valid            <= 1'b0;
    rx_ch.rx_byte          <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.station_address <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_station('0);
    // good frame with a stuffed dle in the payload
    q = {CH_DLE};
    send_frame(8'h00, q, 1'b0);
    // runt: address only
    q = {CH_DLE, CH_STX, 8'h00, CH_DLE, CH_ETX};
    send_bytes(q);
    // restart inside a frame, then a foreign address of all ones
    q = {CH_DLE, CH_STX, 8'hAA, CH_DLE, CH_STX, 8'hFF, 8'h01, 8'h02, CH_DLE, CH_ETX};
    send_bytes(q);
    wait_results();

    plan = '{6'd32, 6'd16, 6'd31, 6'd0, 6'd0};
    plan[3] = ADDR_W'($urandom_range(1, 30));
    foreach (plan[p]) begin
      write_station(plan[p]);
      target = accepted_bytes + 45;
      while (accepted_bytes < target) begin
        send_random_traffic();
      end
      wait_results();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
